[rtl/sfbs_pkg.sv]
// Shared types and constants of the superblock free block stack.
// No dependencies; every other file in rtl but sfbs_ram refers to this package by scoped names.
`timescale 1ns / 1ps

package sfbs_pkg;

  // Region geometry.
  localparam int REGION_BYTES = 4096;
  localparam int HEADER_BYTES = 16;
  localparam int MAX_BLOCKS   = 128;
  localparam int UNITS        = REGION_BYTES / HEADER_BYTES;
  localparam int HDR_SHIFT    = $clog2(HEADER_BYTES);

  // Field and internal widths.
  localparam int KIND_W   = 2;
  localparam int STAT_W   = 2;
  localparam int BLK_W    = 7;
  localparam int CNT_W    = 8;
  localparam int SIZE_W   = 12;
  localparam int STRIDE_W = 9;
  localparam int OFFS_W   = 12;
  localparam int PCT_W    = 7;
  localparam int BYTES_W  = 13;
  localparam int SUM_W    = SIZE_W + 1;
  localparam int ACC_W    = $clog2(UNITS + (1 << STRIDE_W) + 1);
  localparam int PROD_W   = CNT_W + STRIDE_W;
  localparam int NUM_W    = 15;
  localparam int BIT_W    = 3;

  localparam int PCT_SCALE  = 100;
  localparam int SIZE_RESET = 16;

  // Configuration port.
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic REG_SIZE_CLASS = 1'b0;

  typedef enum logic [KIND_W-1:0] {
    KIND_FORMAT = 2'd0,
    KIND_ALLOC  = 2'd1,
    KIND_FREE   = 2'd2,
    KIND_NOP    = 2'd3
  } kind_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_EMPTY     = 2'd1,
    STAT_FULL      = 2'd2,
    STAT_BAD_INDEX = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_FMT_WALK,
    S_POP,
    S_STATS,
    S_DIV,
    S_DONE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    load_item;
    logic    fmt_init;
    logic    fmt_step;
    logic    fmt_end;
    logic    alloc_issue;
    logic    alloc_pop;
    logic    free_push;
    logic    set_status;
    status_t status_code;
    logic    stats_init;
    logic    div_step;
    logic    load_out;
  } dp_cmd_t;

  // Flags from the datapath back to the controller.
  typedef struct packed {
    kind_t kind;
    logic  alloc_empty;
    logic  free_bad;
    logic  free_full;
    logic  fmt_more;
    logic  div_last;
  } dp_stat_t;

endpackage

[rtl/superblock_free_block_stack_core.sv]
// Top level of the superblock free block stack: request and result channels, APB register port.
// Depends on sfbs_pkg, sfbs_ctrl, sfbs_datapath and, through the datapath, sfbs_ram.
`timescale 1ns / 1ps
//
//  Channel   Direction  Handshake             Payload
//  request   in         in_valid / in_stall   kind, block_index
//  result    out        out_valid / out_stall status, granted_block, payload_offset,
//                                             free_blocks, total_blocks,
//                                             fullness_percent, bytes_in_use
//  config    in         APB psel / penable    paddr, pwdata, prdata (size_class_bytes at 0)
//
// One request at a time: after acceptance a request passes through the execute state, a pop state
// for a granted allocate or the link walk for a format, the statistics set-up, the seven-step
// divider for the percentage and the done state, where its result is registered. A format's link
// walk writes one link entry per block and then ends. The next request can be taken in the cycle
// after the result is registered, and meanwhile a stalled result is held in the output register.
// Reset is synchronous; it clears the counters and the stack pointer, sets the size register to
// 16 and leaves the link memory alone, as only formatted or freed entries are read.

module superblock_free_block_stack_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [sfbs_pkg::KIND_W-1:0]       kind,
  input  logic [sfbs_pkg::BLK_W-1:0]        block_index,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [sfbs_pkg::STAT_W-1:0]       status,
  output logic [sfbs_pkg::BLK_W-1:0]        granted_block,
  output logic [sfbs_pkg::OFFS_W-1:0]       payload_offset,
  output logic [sfbs_pkg::CNT_W-1:0]        free_blocks,
  output logic [sfbs_pkg::CNT_W-1:0]        total_blocks,
  output logic [sfbs_pkg::PCT_W-1:0]        fullness_percent,
  output logic [sfbs_pkg::BYTES_W-1:0]      bytes_in_use,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [sfbs_pkg::PADDR_W-1:0]      paddr,
  input  logic [sfbs_pkg::PDATA_W-1:0]      pwdata,
  output logic [sfbs_pkg::PDATA_W-1:0]      prdata,
  output logic                              pready
);

  sfbs_pkg::dp_cmd_t             cmd;
  sfbs_pkg::dp_stat_t            stat;
  logic                          reg_hit;
  logic                          cfg_we;
  logic [sfbs_pkg::SIZE_W-1:0]   size_class;

  // The register port never waits. Only the word index is decoded; the byte lanes
  // below it are ignored.
  assign pready  = 1'b1;
  assign reg_hit = paddr[sfbs_pkg::PADDR_W-1:2] == sfbs_pkg::REG_SIZE_CLASS;
  assign cfg_we  = psel && penable && pwrite && reg_hit;
  assign prdata  = reg_hit ? sfbs_pkg::PDATA_W'(size_class) : '0;

  sfbs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  sfbs_datapath u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .stat             (stat),
    .cfg_we           (cfg_we),
    .cfg_wdata        (pwdata[sfbs_pkg::SIZE_W-1:0]),
    .size_class       (size_class),
    .kind             (kind),
    .block_index      (block_index),
    .status           (status),
    .granted_block    (granted_block),
    .payload_offset   (payload_offset),
    .free_blocks      (free_blocks),
    .total_blocks     (total_blocks),
    .fullness_percent (fullness_percent),
    .bytes_in_use     (bytes_in_use)
  );

  // An accepted request keeps the block busy for at least the following cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("request channel open directly after an accepted request");

  // The free count never exceeds the number of formatted blocks.
  a_free_le_total: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> free_blocks <= total_blocks)
    else $error("free count above block count");

  // The percentage stays within its range.
  a_pct_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> fullness_percent <= 7'(sfbs_pkg::PCT_SCALE))
    else $error("fullness percentage out of range");

  // A refused allocate only happens with nothing free.
  a_empty_means_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == sfbs_pkg::STAT_EMPTY |-> free_blocks == '0)
    else $error("allocate refused while blocks are free");

endmodule

[rtl/sfbs_ram.sv]
// Generic single write port, single read port RAM with a registered read.
// No dependencies.
`timescale 1ns / 1ps

module sfbs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/sfbs_datapath.sv]
// Datapath: size register, stack pointers, link memory, multiplier, divider and result register.
// Depends on sfbs_pkg and sfbs_ram.
`timescale 1ns / 1ps

module sfbs_datapath (
  input  logic                            clk,
  input  logic                            rst,
  input  sfbs_pkg::dp_cmd_t               cmd,
  output sfbs_pkg::dp_stat_t              stat,
  input  logic                            cfg_we,
  input  logic [sfbs_pkg::SIZE_W-1:0]     cfg_wdata,
  output logic [sfbs_pkg::SIZE_W-1:0]     size_class,
  input  logic [sfbs_pkg::KIND_W-1:0]     kind,
  input  logic [sfbs_pkg::BLK_W-1:0]      block_index,
  output logic [sfbs_pkg::STAT_W-1:0]     status,
  output logic [sfbs_pkg::BLK_W-1:0]      granted_block,
  output logic [sfbs_pkg::OFFS_W-1:0]     payload_offset,
  output logic [sfbs_pkg::CNT_W-1:0]      free_blocks,
  output logic [sfbs_pkg::CNT_W-1:0]      total_blocks,
  output logic [sfbs_pkg::PCT_W-1:0]      fullness_percent,
  output logic [sfbs_pkg::BYTES_W-1:0]    bytes_in_use
);

  sfbs_pkg::kind_t                 item_kind;
  logic [sfbs_pkg::BLK_W-1:0]      item_idx;
  logic [sfbs_pkg::STRIDE_W-1:0]   stride;
  logic [sfbs_pkg::ACC_W-1:0]      acc;
  logic [sfbs_pkg::CNT_W-1:0]      fmt_idx;
  logic [sfbs_pkg::CNT_W-1:0]      block_count;
  logic [sfbs_pkg::CNT_W-1:0]      free_count;
  logic [sfbs_pkg::BLK_W-1:0]      stack_top;
  sfbs_pkg::status_t               res_status;
  logic [sfbs_pkg::BLK_W-1:0]      res_granted;
  logic [sfbs_pkg::OFFS_W-1:0]     res_offset;
  logic [sfbs_pkg::BYTES_W-1:0]    res_bytes;
  logic [sfbs_pkg::NUM_W-1:0]      rem;
  logic [sfbs_pkg::PCT_W-1:0]      quot;
  logic [sfbs_pkg::BIT_W-1:0]      bit_cnt;

  logic [sfbs_pkg::SUM_W-1:0]      stride_sum;
  logic [sfbs_pkg::STRIDE_W-1:0]   stride_calc;
  logic [sfbs_pkg::CNT_W-1:0]      used;
  logic [sfbs_pkg::CNT_W-1:0]      mul_a;
  logic [sfbs_pkg::PROD_W-1:0]     prod;
  logic [sfbs_pkg::NUM_W-1:0]      div_shift;
  logic                            div_fit;

  logic                            ram_we;
  logic [sfbs_pkg::BLK_W-1:0]      ram_waddr;
  logic [sfbs_pkg::BLK_W-1:0]      ram_wdata;
  logic [sfbs_pkg::BLK_W-1:0]      ram_rdata;

  // Stride in header units: one header plus the payload rounded up to headers.
  assign stride_sum  = sfbs_pkg::SUM_W'(size_class) + sfbs_pkg::SUM_W'(2 * sfbs_pkg::HEADER_BYTES - 1);
  assign stride_calc = sfbs_pkg::STRIDE_W'(stride_sum >> sfbs_pkg::HDR_SHIFT);

  assign used  = block_count - free_count;
  assign mul_a = cmd.alloc_pop ? sfbs_pkg::CNT_W'(res_granted) : used;
  assign prod  = sfbs_pkg::PROD_W'(mul_a) * sfbs_pkg::PROD_W'(stride);

  assign div_shift = sfbs_pkg::NUM_W'(block_count) << bit_cnt;
  assign div_fit   = rem >= div_shift;

  assign stat.kind        = item_kind;
  assign stat.alloc_empty = free_count == '0;
  assign stat.free_bad    = sfbs_pkg::CNT_W'(item_idx) >= block_count;
  assign stat.free_full   = free_count >= block_count;
  assign stat.fmt_more    = (fmt_idx < sfbs_pkg::CNT_W'(sfbs_pkg::MAX_BLOCKS))
                            && (acc <= sfbs_pkg::ACC_W'(sfbs_pkg::UNITS));
  assign stat.div_last    = bit_cnt == '0;

  // Link memory write port: the format walk and a free share it.
  always_comb begin
    ram_we    = cmd.fmt_step | cmd.free_push;
    ram_waddr = cmd.fmt_step ? fmt_idx[sfbs_pkg::BLK_W-1:0] : item_idx;
    ram_wdata = cmd.fmt_step ? sfbs_pkg::BLK_W'(fmt_idx + 1'b1) : stack_top;
  end

  sfbs_ram #(
    .WIDTH (sfbs_pkg::BLK_W),
    .DEPTH (sfbs_pkg::MAX_BLOCKS)
  ) u_link_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.alloc_issue),
    .raddr (stack_top),
    .rdata (ram_rdata)
  );

  // Control state: configuration and stack bookkeeping.
  always_ff @(posedge clk) begin
    if (rst) begin
      size_class  <= sfbs_pkg::SIZE_W'(sfbs_pkg::SIZE_RESET);
      block_count <= '0;
      free_count  <= '0;
      stack_top   <= '0;
      stride      <= '0;
    end else begin
      if (cfg_we) begin
        size_class <= cfg_wdata;
      end
      if (cmd.fmt_init) begin
        stride <= stride_calc;
      end
      if (cmd.fmt_end) begin
        block_count <= fmt_idx;
        free_count  <= fmt_idx;
        stack_top   <= '0;
      end
      if (cmd.alloc_pop) begin
        stack_top  <= ram_rdata;
        free_count <= free_count - 1'b1;
      end
      if (cmd.free_push) begin
        stack_top  <= item_idx;
        free_count <= free_count + 1'b1;
      end
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_kind   <= sfbs_pkg::kind_t'(kind);
      item_idx    <= block_index;
      res_status  <= sfbs_pkg::STAT_OK;
      res_granted <= '0;
      res_offset  <= '0;
    end
    if (cmd.set_status) begin
      res_status <= cmd.status_code;
    end
    if (cmd.fmt_init) begin
      acc     <= sfbs_pkg::ACC_W'(stride_calc);
      fmt_idx <= '0;
    end
    if (cmd.fmt_step) begin
      acc     <= acc + sfbs_pkg::ACC_W'(stride);
      fmt_idx <= fmt_idx + 1'b1;
    end
    if (cmd.alloc_issue) begin
      res_granted <= stack_top;
    end
    if (cmd.alloc_pop) begin
      res_offset <= sfbs_pkg::OFFS_W'((prod << sfbs_pkg::HDR_SHIFT) + sfbs_pkg::HEADER_BYTES);
    end
    if (cmd.stats_init) begin
      res_bytes <= sfbs_pkg::BYTES_W'(prod << sfbs_pkg::HDR_SHIFT);
      rem       <= sfbs_pkg::NUM_W'(used) * sfbs_pkg::NUM_W'(sfbs_pkg::PCT_SCALE);
      quot      <= '0;
      bit_cnt   <= sfbs_pkg::BIT_W'(sfbs_pkg::PCT_W - 1);
    end
    if (cmd.div_step) begin
      if (div_fit) begin
        rem           <= rem - div_shift;
        quot[bit_cnt] <= 1'b1;
      end
      bit_cnt <= bit_cnt - 1'b1;
    end
  end

  // Result register towards the output channel.
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      status           <= res_status;
      granted_block    <= res_granted;
      payload_offset   <= res_offset;
      free_blocks      <= free_count;
      total_blocks     <= block_count;
      fullness_percent <= (block_count == '0) ? '0 : quot;
      bytes_in_use     <= res_bytes;
    end
  end

endmodule

[rtl/sfbs_ctrl.sv]
// Controller state machine sequencing format, allocate, free and the statistics.
// Depends on sfbs_pkg.
`timescale 1ns / 1ps

module sfbs_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  sfbs_pkg::dp_stat_t  stat,
  output sfbs_pkg::dp_cmd_t   cmd
);

  sfbs_pkg::state_t state;
  sfbs_pkg::state_t state_next;
  logic             out_free;

  assign in_stall = state != sfbs_pkg::S_IDLE;
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= sfbs_pkg::S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      sfbs_pkg::S_IDLE: begin
        if (in_valid) begin
          state_next = sfbs_pkg::S_EXEC;
        end
      end
      sfbs_pkg::S_EXEC: begin
        case (stat.kind)
          sfbs_pkg::KIND_FORMAT: state_next = sfbs_pkg::S_FMT_WALK;
          sfbs_pkg::KIND_ALLOC:  state_next = stat.alloc_empty ? sfbs_pkg::S_STATS
                                                               : sfbs_pkg::S_POP;
          default:               state_next = sfbs_pkg::S_STATS;
        endcase
      end
      sfbs_pkg::S_FMT_WALK: begin
        if (!stat.fmt_more) begin
          state_next = sfbs_pkg::S_STATS;
        end
      end
      sfbs_pkg::S_POP:   state_next = sfbs_pkg::S_STATS;
      sfbs_pkg::S_STATS: state_next = sfbs_pkg::S_DIV;
      sfbs_pkg::S_DIV: begin
        if (stat.div_last) begin
          state_next = sfbs_pkg::S_DONE;
        end
      end
      sfbs_pkg::S_DONE: begin
        if (out_free) begin
          state_next = sfbs_pkg::S_IDLE;
        end
      end
      default: state_next = sfbs_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.status_code = sfbs_pkg::STAT_OK;
    case (state)
      sfbs_pkg::S_IDLE: begin
        cmd.load_item = in_valid;
      end
      sfbs_pkg::S_EXEC: begin
        case (stat.kind)
          sfbs_pkg::KIND_FORMAT: cmd.fmt_init = 1'b1;
          sfbs_pkg::KIND_ALLOC: begin
            if (stat.alloc_empty) begin
              cmd.set_status  = 1'b1;
              cmd.status_code = sfbs_pkg::STAT_EMPTY;
            end else begin
              cmd.alloc_issue = 1'b1;
            end
          end
          sfbs_pkg::KIND_FREE: begin
            if (stat.free_bad) begin
              cmd.set_status  = 1'b1;
              cmd.status_code = sfbs_pkg::STAT_BAD_INDEX;
            end else if (stat.free_full) begin
              cmd.set_status  = 1'b1;
              cmd.status_code = sfbs_pkg::STAT_FULL;
            end else begin
              cmd.free_push = 1'b1;
            end
          end
          default: cmd.set_status = 1'b0;
        endcase
      end
      sfbs_pkg::S_FMT_WALK: begin
        cmd.fmt_step = stat.fmt_more;
        cmd.fmt_end  = !stat.fmt_more;
      end
      sfbs_pkg::S_POP:   cmd.alloc_pop  = 1'b1;
      sfbs_pkg::S_STATS: cmd.stats_init = 1'b1;
      sfbs_pkg::S_DIV:   cmd.div_step   = 1'b1;
      sfbs_pkg::S_DONE:  cmd.load_out   = out_free;
      default:           cmd.load_item  = 1'b0;
    endcase
  end

endmodule
